FILE: src/adrcf_pkg.sv
`timescale 1ns / 1ps
// Package for the fhan tracking differentiator: widths, register indexes,
// controller states, datapath commands and shared arithmetic helpers.
// No dependencies.
package adrcf_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int STATE_WIDTH_DEF = 48;

    localparam int IN_W   = 32;
    localparam int OUT_W  = 48;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 2;
    localparam int R_W    = 24;
    localparam int H_W    = 24;
    localparam int N0_W   = 4;
    localparam int H0_W   = H_W + N0_W;
    localparam int HSQ_W  = 2 * H0_W - H_W;
    localparam int D_W    = R_W + HSQ_W;
    localparam int CNT_W  = 6;

    // shift-add multiplier: one 8-bit digit of the multiplier per cycle
    localparam int MUL_DIG   = 8;
    localparam int MUL_STEPS = 64 / MUL_DIG;
    // square root: two radicand bits per cycle over a 128-bit radicand
    localparam int SQRT_STEPS = 64;
    localparam int REM_W      = 68;

    localparam logic [CFG_W-1:0] GAIN_R_RST    = 24'd1000000;
    localparam logic [CFG_W-1:0] STEP_H_RST    = 24'd83886;
    localparam logic [N0_W-1:0]  FILTER_N0_RST = 4'd2;

    localparam logic [IDX_W-1:0] REG_GAIN_R    = 2'd0;
    localparam logic [IDX_W-1:0] REG_STEP_H    = 2'd1;
    localparam logic [IDX_W-1:0] REG_FILTER_N0 = 2'd2;

    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [4:0] {
        ST_IDLE, ST_HSQ, ST_D, ST_A0_INIT, ST_A0_MUL, ST_A0_FIN, ST_DIFF, ST_Y,
        ST_AY, ST_T, ST_DT_INIT, ST_DT_MUL, ST_SQ_INIT, ST_SQ, ST_HALF, ST_A,
        ST_FSEL, ST_NUM_INIT, ST_NUM_MUL, ST_DIV_INIT, ST_DIV, ST_FH_DIV,
        ST_X1_INIT, ST_X1_MUL, ST_X1_FIN, ST_X1, ST_X2_INIT, ST_X2_MUL,
        ST_X2_FIN, ST_X2, ST_DONE
    } ctrl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_HSQ, OP_D, OP_MUL_A0, OP_MUL_DT, OP_MUL_NUM,
        OP_MUL_X1, OP_MUL_X2, OP_MUL_STEP, OP_A0, OP_MFIN, OP_DIFF, OP_Y,
        OP_AY, OP_T, OP_SQ_INIT, OP_SQ_STEP, OP_HALF, OP_A, OP_FH_SAT,
        OP_DIV_INIT, OP_DIV_STEP, OP_FH_DIV, OP_X1, OP_X2, OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic d_zero;
        logic a_band;
    } dp_status_t;

    // saturate a 65-bit signed sum to the signed 64-bit range
    function automatic logic [63:0] sat64(input logic signed [64:0] s);
        logic [63:0] res;
        if (s[64] != s[63]) begin
            res = s[64] ? INT64_MIN : INT64_MAX;
        end else begin
            res = s[63:0];
        end
        return res;
    endfunction

    function automatic logic [63:0] mag64(input logic [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

    // (|x| * b) >> H_W, saturated to INT64_MAX magnitude, sign restored
    function automatic logic [63:0] mul_fin(input logic [127:0] p, input logic neg);
        logic [63:0] m;
        if ((|p[127:64+H_W]) || p[63+H_W]) begin
            m = INT64_MAX;
        end else begin
            m = p[63+H_W:H_W];
        end
        return neg ? (~m + 64'd1) : m;
    endfunction

endpackage

FILE: src/adrcf_in_if.sv
`timescale 1ns / 1ps
// Input channel: one target sample per beat.
// Depends on adrcf_pkg.
interface adrcf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [adrcf_pkg::IN_W-1:0]   target;

    modport source (output valid, output target, input ready);
    modport sink (input valid, input target, output ready);
endinterface

FILE: src/adrcf_out_if.sv
`timescale 1ns / 1ps
// Result channel: tracked value, tracked rate and steering acceleration per beat.
// Depends on adrcf_pkg.
interface adrcf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [adrcf_pkg::OUT_W-1:0]  tracked_value;
    logic signed [adrcf_pkg::OUT_W-1:0]  tracked_rate;
    logic signed [adrcf_pkg::OUT_W-1:0]  steer_accel;

    modport source (output valid, output tracked_value, output tracked_rate,
                    output steer_accel, input ready);
    modport sink (input valid, input tracked_value, input tracked_rate,
                  input steer_accel, output ready);
endinterface

FILE: src/adrcf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the tracking differentiator: walks one sample through the datapath.
// Depends on adrcf_pkg.
module adrcf_ctrl #(
    parameter int FRAC_BITS = adrcf_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  adrcf_pkg::dp_status_t  status,
    output adrcf_pkg::dp_cmd_t     cmd
);

    localparam int QUO_W = adrcf_pkg::H_W + FRAC_BITS;

    adrcf_pkg::ctrl_state_t           state_reg, state_next;
    logic [adrcf_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adrcf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        cmd.op         = adrcf_pkg::OP_NONE;
        in_ready       = 1'b0;
        case (state_reg)
            adrcf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = adrcf_pkg::OP_LOAD;
                    state_next = adrcf_pkg::ST_HSQ;
                end
            end
            adrcf_pkg::ST_HSQ:
            begin
                cmd.op     = adrcf_pkg::OP_HSQ;
                state_next = adrcf_pkg::ST_D;
            end
            adrcf_pkg::ST_D:
            begin
                cmd.op     = adrcf_pkg::OP_D;
                state_next = adrcf_pkg::ST_A0_INIT;
            end
            adrcf_pkg::ST_A0_INIT:
            begin
                cmd.op     = adrcf_pkg::OP_MUL_A0;
                cnt_next   = adrcf_pkg::CNT_W'(adrcf_pkg::MUL_STEPS - 1);
                state_next = adrcf_pkg::ST_A0_MUL;
            end
            adrcf_pkg::ST_A0_MUL:
            begin
                cmd.op   = adrcf_pkg::OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = adrcf_pkg::ST_A0_FIN;
                end
            end
            adrcf_pkg::ST_A0_FIN:
            begin
                cmd.op     = adrcf_pkg::OP_A0;
                state_next = adrcf_pkg::ST_DIFF;
            end
            adrcf_pkg::ST_DIFF:
            begin
                cmd.op     = adrcf_pkg::OP_DIFF;
                state_next = adrcf_pkg::ST_Y;
            end
            adrcf_pkg::ST_Y:
            begin
                cmd.op     = adrcf_pkg::OP_Y;
                state_next = adrcf_pkg::ST_AY;
            end
            adrcf_pkg::ST_AY:
            begin
                cmd.op     = adrcf_pkg::OP_AY;
                state_next = adrcf_pkg::ST_T;
            end
            adrcf_pkg::ST_T:
            begin
                cmd.op     = adrcf_pkg::OP_T;
                state_next = adrcf_pkg::ST_DT_INIT;
            end
            adrcf_pkg::ST_DT_INIT:
            begin
                cmd.op     = adrcf_pkg::OP_MUL_DT;
                cnt_next   = adrcf_pkg::CNT_W'(adrcf_pkg::MUL_STEPS - 1);
                state_next = adrcf_pkg::ST_DT_MUL;
            end
            adrcf_pkg::ST_DT_MUL:
            begin
                cmd.op   = adrcf_pkg::OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = adrcf_pkg::ST_SQ_INIT;
                end
            end
            adrcf_pkg::ST_SQ_INIT:
            begin
                cmd.op     = adrcf_pkg::OP_SQ_INIT;
                cnt_next   = adrcf_pkg::CNT_W'(adrcf_pkg::SQRT_STEPS - 1);
                state_next = adrcf_pkg::ST_SQ;
            end
            adrcf_pkg::ST_SQ:
            begin
                cmd.op   = adrcf_pkg::OP_SQ_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = adrcf_pkg::ST_HALF;
                end
            end
            adrcf_pkg::ST_HALF:
            begin
                cmd.op     = adrcf_pkg::OP_HALF;
                state_next = adrcf_pkg::ST_A;
            end
            adrcf_pkg::ST_A:
            begin
                cmd.op     = adrcf_pkg::OP_A;
                state_next = adrcf_pkg::ST_FSEL;
            end
            adrcf_pkg::ST_FSEL:
            begin
                // bang-bang value is written here; the linear zone overwrites it
                cmd.op = adrcf_pkg::OP_FH_SAT;
                if (!status.d_zero && status.a_band)
                begin
                    state_next = adrcf_pkg::ST_NUM_INIT;
                end
                else
                begin
                    state_next = adrcf_pkg::ST_X1_INIT;
                end
            end
            adrcf_pkg::ST_NUM_INIT:
            begin
                cmd.op     = adrcf_pkg::OP_MUL_NUM;
                cnt_next   = adrcf_pkg::CNT_W'(adrcf_pkg::MUL_STEPS - 1);
                state_next = adrcf_pkg::ST_NUM_MUL;
            end
            adrcf_pkg::ST_NUM_MUL:
            begin
                cmd.op   = adrcf_pkg::OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = adrcf_pkg::ST_DIV_INIT;
                end
            end
            adrcf_pkg::ST_DIV_INIT:
            begin
                cmd.op     = adrcf_pkg::OP_DIV_INIT;
                cnt_next   = adrcf_pkg::CNT_W'(QUO_W - 1);
                state_next = adrcf_pkg::ST_DIV;
            end
            adrcf_pkg::ST_DIV:
            begin
                cmd.op   = adrcf_pkg::OP_DIV_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = adrcf_pkg::ST_FH_DIV;
                end
            end
            adrcf_pkg::ST_FH_DIV:
            begin
                cmd.op     = adrcf_pkg::OP_FH_DIV;
                state_next = adrcf_pkg::ST_X1_INIT;
            end
            adrcf_pkg::ST_X1_INIT:
            begin
                cmd.op     = adrcf_pkg::OP_MUL_X1;
                cnt_next   = adrcf_pkg::CNT_W'(adrcf_pkg::MUL_STEPS - 1);
                state_next = adrcf_pkg::ST_X1_MUL;
            end
            adrcf_pkg::ST_X1_MUL:
            begin
                cmd.op   = adrcf_pkg::OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = adrcf_pkg::ST_X1_FIN;
                end
            end
            adrcf_pkg::ST_X1_FIN:
            begin
                cmd.op     = adrcf_pkg::OP_MFIN;
                state_next = adrcf_pkg::ST_X1;
            end
            adrcf_pkg::ST_X1:
            begin
                cmd.op     = adrcf_pkg::OP_X1;
                state_next = adrcf_pkg::ST_X2_INIT;
            end
            adrcf_pkg::ST_X2_INIT:
            begin
                cmd.op     = adrcf_pkg::OP_MUL_X2;
                cnt_next   = adrcf_pkg::CNT_W'(adrcf_pkg::MUL_STEPS - 1);
                state_next = adrcf_pkg::ST_X2_MUL;
            end
            adrcf_pkg::ST_X2_MUL:
            begin
                cmd.op   = adrcf_pkg::OP_MUL_STEP;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = adrcf_pkg::ST_X2_FIN;
                end
            end
            adrcf_pkg::ST_X2_FIN:
            begin
                cmd.op     = adrcf_pkg::OP_MFIN;
                state_next = adrcf_pkg::ST_X2;
            end
            adrcf_pkg::ST_X2:
            begin
                cmd.op     = adrcf_pkg::OP_X2;
                state_next = adrcf_pkg::ST_DONE;
            end
            adrcf_pkg::ST_DONE:
            begin
                // hold until the output register is free or drains this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = adrcf_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = adrcf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = adrcf_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/adrcf_dp.sv
`timescale 1ns / 1ps
// Datapath of the tracking differentiator: config registers, state, shift-add
// multiplier, digit square root, restoring divider and output registers.
// Depends on adrcf_pkg.
module adrcf_dp #(
    parameter int FRAC_BITS   = adrcf_pkg::FRAC_BITS_DEF,
    parameter int STATE_WIDTH = adrcf_pkg::STATE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [adrcf_pkg::IDX_W-1:0]           cfg_index,
    input  logic [adrcf_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [adrcf_pkg::IN_W-1:0]     target,
    input  adrcf_pkg::dp_cmd_t                    cmd,
    output adrcf_pkg::dp_status_t                 status,
    output logic signed [adrcf_pkg::OUT_W-1:0]    tracked_value,
    output logic signed [adrcf_pkg::OUT_W-1:0]    tracked_rate,
    output logic signed [adrcf_pkg::OUT_W-1:0]    steer_accel
);

    localparam int QUO_W  = adrcf_pkg::H_W + FRAC_BITS;
    localparam int D_SH   = adrcf_pkg::H_W - FRAC_BITS;
    localparam int DIV_SH = 128 - QUO_W;
    localparam logic [63:0] ST_MAX = {{(65 - STATE_WIDTH){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
    localparam logic [63:0] ST_MIN = ~ST_MAX;

    // configuration
    logic [adrcf_pkg::R_W-1:0]    gain_r_reg;
    logic [adrcf_pkg::H_W-1:0]    step_h_reg;
    logic [adrcf_pkg::N0_W-1:0]   filter_n0_reg;

    // tracker state
    logic signed [STATE_WIDTH-1:0] x1_reg;
    logic signed [STATE_WIDTH-1:0] x2_reg;

    // working registers
    logic signed [adrcf_pkg::IN_W-1:0] v_reg;
    logic [adrcf_pkg::H0_W-1:0]        h0_reg;
    logic [adrcf_pkg::HSQ_W-1:0]       hsq_reg;
    logic [adrcf_pkg::D_W-1:0]         d_reg;
    logic [63:0]                       a0_reg;
    logic [63:0]                       p_reg;
    logic [63:0]                       diff_reg;
    logic [63:0]                       y_reg;
    logic [63:0]                       ay_reg;
    logic [63:0]                       t_reg;
    logic [62:0]                       half_reg;
    logic [63:0]                       a_reg;
    logic [63:0]                       fh_reg;
    logic [63:0]                       mcand_reg;
    logic [63:0]                       mplier_reg;
    logic                              neg_reg;
    logic [127:0]                      prod_reg;
    logic [adrcf_pkg::REM_W-1:0]       rem_reg;
    logic [63:0]                       root_reg;
    logic [adrcf_pkg::OUT_W-1:0]       value_out_reg;
    logic [adrcf_pkg::OUT_W-1:0]       rate_out_reg;
    logic [adrcf_pkg::OUT_W-1:0]       accel_out_reg;

    logic signed [63:0]                x1_64;
    logic signed [63:0]                x2_64;
    logic signed [63:0]                v_64;
    logic [63:0]                       d_64;
    logic [63:0]                       rr;
    logic [71:0]                       partial;
    logic [71:0]                       acc_sum;
    logic [adrcf_pkg::REM_W-1:0]       sq_rem;
    logic [adrcf_pkg::REM_W-1:0]       sq_trial;
    logic [adrcf_pkg::REM_W-1:0]       dv_rem;
    logic [67:0]                       t_sum;
    logic                              y_pos;
    logic                              y_neg;
    logic                              a_pos;
    logic                              a_neg;
    logic [63:0]                       half_adj;
    logic [63:0]                       a_lin;
    logic [63:0]                       a_bang;
    logic [63:0]                       fh_bang;
    logic [63:0]                       fh_div;

    function automatic logic [63:0] clamp_st(input logic signed [64:0] s);
        logic [63:0] res;
        if (s > $signed({1'b0, ST_MAX}))
        begin
            res = ST_MAX;
        end
        else if (s < $signed({1'b1, ST_MIN}))
        begin
            res = ST_MIN;
        end
        else
        begin
            res = s[63:0];
        end
        return res;
    endfunction

    assign x1_64 = 64'(x1_reg);
    assign x2_64 = 64'(x2_reg);
    assign v_64  = 64'(v_reg);
    assign d_64  = 64'(d_reg);
    assign rr    = 64'(gain_r_reg) << FRAC_BITS;

    assign status.d_zero = (d_reg == '0);
    assign status.a_band = (adrcf_pkg::mag64(a_reg) < d_64);

    always_comb
    begin
        partial  = mcand_reg * mplier_reg[adrcf_pkg::MUL_DIG-1:0];
        acc_sum  = 72'(prod_reg[127:64]) + partial;
        sq_rem   = {rem_reg[adrcf_pkg::REM_W-3:0], prod_reg[127:126]};
        sq_trial = adrcf_pkg::REM_W'({root_reg, 2'b01});
        dv_rem   = {rem_reg[adrcf_pkg::REM_W-2:0], prod_reg[127]};
        t_sum    = 68'(d_reg) + 68'({ay_reg, 3'b000});
        y_pos    = !y_reg[63] && (y_reg != '0);
        y_neg    = y_reg[63];
        a_pos    = !a_reg[63] && (a_reg != '0);
        a_neg    = a_reg[63];
        if (y_pos)
        begin
            half_adj = {1'b0, half_reg};
        end
        else if (y_neg)
        begin
            half_adj = ~{1'b0, half_reg} + 64'd1;
        end
        else
        begin
            half_adj = '0;
        end
        a_lin  = adrcf_pkg::sat64(65'($signed(a0_reg)) + 65'($signed(y_reg)));
        a_bang = adrcf_pkg::sat64(65'($signed(a0_reg)) + 65'($signed(half_adj)));
        if (status.d_zero)
        begin
            fh_bang = '0;
        end
        else if (a_pos)
        begin
            fh_bang = clamp_st(-$signed({1'b0, rr}));
        end
        else if (a_neg)
        begin
            fh_bang = clamp_st($signed({1'b0, rr}));
        end
        else
        begin
            fh_bang = '0;
        end
        fh_div = a_pos ? clamp_st(-$signed({1'b0, root_reg}))
                       : clamp_st($signed({1'b0, root_reg}));
    end

    // control state: configuration and the tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_r_reg    <= adrcf_pkg::GAIN_R_RST;
            step_h_reg    <= adrcf_pkg::STEP_H_RST;
            filter_n0_reg <= adrcf_pkg::FILTER_N0_RST;
            x1_reg        <= '0;
            x2_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    adrcf_pkg::REG_GAIN_R:    gain_r_reg    <= cfg_data;
                    adrcf_pkg::REG_STEP_H:    step_h_reg    <= cfg_data;
                    adrcf_pkg::REG_FILTER_N0: filter_n0_reg <= cfg_data[adrcf_pkg::N0_W-1:0];
                    default:                  ;
                endcase
            end
            if (cmd.op == adrcf_pkg::OP_X1)
            begin
                x1_reg <= STATE_WIDTH'(clamp_st(65'(x1_64) + 65'($signed(p_reg))));
            end
            if (cmd.op == adrcf_pkg::OP_X2)
            begin
                x2_reg <= STATE_WIDTH'(clamp_st(65'(x2_64) + 65'($signed(p_reg))));
            end
        end
    end

    // payload: one step of the current operation
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            adrcf_pkg::OP_LOAD:
            begin
                v_reg  <= target;
                h0_reg <= filter_n0_reg * step_h_reg;
            end
            adrcf_pkg::OP_HSQ:
            begin
                hsq_reg <= adrcf_pkg::HSQ_W'((2 * adrcf_pkg::H0_W)'(h0_reg * h0_reg)
                                             >> adrcf_pkg::H_W);
            end
            adrcf_pkg::OP_D:
            begin
                d_reg <= adrcf_pkg::D_W'((adrcf_pkg::D_W'(gain_r_reg) * adrcf_pkg::D_W'(hsq_reg))
                                         >> D_SH);
            end
            adrcf_pkg::OP_MUL_A0:
            begin
                mcand_reg  <= adrcf_pkg::mag64(x2_64);
                mplier_reg <= 64'(h0_reg);
                neg_reg    <= x2_64[63];
                prod_reg   <= '0;
            end
            adrcf_pkg::OP_MUL_DT:
            begin
                mcand_reg  <= d_64;
                mplier_reg <= t_reg;
                neg_reg    <= 1'b0;
                prod_reg   <= '0;
            end
            adrcf_pkg::OP_MUL_NUM:
            begin
                mcand_reg  <= rr;
                mplier_reg <= adrcf_pkg::mag64(a_reg);
                neg_reg    <= 1'b0;
                prod_reg   <= '0;
            end
            adrcf_pkg::OP_MUL_X1:
            begin
                mcand_reg  <= adrcf_pkg::mag64(x2_64);
                mplier_reg <= 64'(step_h_reg);
                neg_reg    <= x2_64[63];
                prod_reg   <= '0;
            end
            adrcf_pkg::OP_MUL_X2:
            begin
                mcand_reg  <= adrcf_pkg::mag64(fh_reg);
                mplier_reg <= 64'(step_h_reg);
                neg_reg    <= fh_reg[63];
                prod_reg   <= '0;
            end
            adrcf_pkg::OP_MUL_STEP:
            begin
                prod_reg   <= {acc_sum, prod_reg[63:adrcf_pkg::MUL_DIG]};
                mplier_reg <= mplier_reg >> adrcf_pkg::MUL_DIG;
            end
            adrcf_pkg::OP_A0:
            begin
                a0_reg <= adrcf_pkg::mul_fin(prod_reg, neg_reg);
            end
            adrcf_pkg::OP_MFIN:
            begin
                p_reg <= adrcf_pkg::mul_fin(prod_reg, neg_reg);
            end
            adrcf_pkg::OP_DIFF:
            begin
                diff_reg <= adrcf_pkg::sat64(65'(x1_64) - 65'(v_64));
            end
            adrcf_pkg::OP_Y:
            begin
                y_reg <= adrcf_pkg::sat64(65'($signed(diff_reg)) + 65'($signed(a0_reg)));
            end
            adrcf_pkg::OP_AY:
            begin
                ay_reg <= adrcf_pkg::mag64(y_reg);
            end
            adrcf_pkg::OP_T:
            begin
                t_reg <= (|t_sum[67:64]) ? '1 : t_sum[63:0];
            end
            adrcf_pkg::OP_SQ_INIT:
            begin
                rem_reg  <= '0;
                root_reg <= '0;
            end
            adrcf_pkg::OP_SQ_STEP:
            begin
                prod_reg <= prod_reg << 2;
                if (sq_rem >= sq_trial)
                begin
                    rem_reg  <= sq_rem - sq_trial;
                    root_reg <= {root_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= sq_rem;
                    root_reg <= {root_reg[62:0], 1'b0};
                end
            end
            adrcf_pkg::OP_HALF:
            begin
                half_reg <= 63'((root_reg - d_64) >> 1);
            end
            adrcf_pkg::OP_A:
            begin
                a_reg <= (ay_reg < d_64) ? a_lin : a_bang;
            end
            adrcf_pkg::OP_FH_SAT:
            begin
                fh_reg <= fh_bang;
            end
            adrcf_pkg::OP_DIV_INIT:
            begin
                // numerator is below d * 2^QUO_W, so the top part starts below d
                rem_reg  <= adrcf_pkg::REM_W'(prod_reg >> QUO_W);
                prod_reg <= prod_reg << DIV_SH;
                root_reg <= '0;
            end
            adrcf_pkg::OP_DIV_STEP:
            begin
                prod_reg <= prod_reg << 1;
                if (dv_rem >= adrcf_pkg::REM_W'(d_reg))
                begin
                    rem_reg  <= dv_rem - adrcf_pkg::REM_W'(d_reg);
                    root_reg <= {root_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= dv_rem;
                    root_reg <= {root_reg[62:0], 1'b0};
                end
            end
            adrcf_pkg::OP_FH_DIV:
            begin
                fh_reg <= fh_div;
            end
            adrcf_pkg::OP_OUT:
            begin
                value_out_reg <= x1_64[adrcf_pkg::OUT_W-1:0];
                rate_out_reg  <= x2_64[adrcf_pkg::OUT_W-1:0];
                accel_out_reg <= fh_reg[adrcf_pkg::OUT_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assign tracked_value = value_out_reg;
    assign tracked_rate  = rate_out_reg;
    assign steer_accel   = accel_out_reg;

endmodule

FILE: src/adrc_fhan_tracking_differentiator_unit.sv
`timescale 1ns / 1ps
// Top level of the fhan tracking differentiator: sequencer plus datapath.
// Depends on adrcf_pkg, adrcf_in_if, adrcf_out_if, adrcf_ctrl, adrcf_dp.
//
// Usage:
//   sample  - one beat carries one target sample (signed, FRAC_BITS fraction bits).
//   result  - one beat per sample: tracked value, tracked rate and the steering
//             acceleration of that step, 48 bits each.
//   cfg_we/cfg_index/cfg_data - write gain_r (0), step_h (1), filter_n0 (2);
//             other indexes are dropped. Write only while the block is idle.
// Sequence: an accepted sample passes the 64-step square root and four passes of
//   the 8-bit-per-cycle multiplier on the bang-bang path; the linear-zone path
//   adds a fifth multiplier pass and the restoring divide before the result beat
//   goes valid.
// Samples: a new sample is taken only once the previous result is parked; the
//   sequencer is idle again in the cycle after parking and accepts the sample there.
// Reset: the tracker state clears to zero, config registers take their defaults.
// Stall: a result waiting on the receiver holds in the output register while
//   the next sample is already processed; the sequencer holds at its last step
//   only if a second result finishes before the first is taken.
module adrc_fhan_tracking_differentiator_unit #(
    parameter int FRAC_BITS   = adrcf_pkg::FRAC_BITS_DEF,
    parameter int STATE_WIDTH = adrcf_pkg::STATE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    adrcf_in_if.sink                          sample,
    adrcf_out_if.source                       result,
    input  logic                              cfg_we,
    input  logic [adrcf_pkg::IDX_W-1:0]       cfg_index,
    input  logic [adrcf_pkg::CFG_W-1:0]       cfg_data
);

    adrcf_pkg::dp_cmd_t     cmd;
    adrcf_pkg::dp_status_t  status;

    // sequencer: owns the handshakes and the iteration counter
    adrcf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: arithmetic, state and the result register
    adrcf_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .STATE_WIDTH (STATE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .target        (sample.target),
        .cmd           (cmd),
        .status        (status),
        .tracked_value (result.tracked_value),
        .tracked_rate  (result.tracked_rate),
        .steer_accel   (result.steer_accel)
    );

endmodule
